FILE: rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants of the first-fit segment allocator
// Table depth, unit size, status codes, commands and controller states.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned MaxSegments  = 16;
  localparam int unsigned BytesPerUnit = 4;
  localparam int unsigned IdxW         = $clog2(MaxSegments);
  localparam int unsigned CntW         = $clog2(MaxSegments + 1);
  localparam int unsigned UnitShift    = $clog2(BytesPerUnit);

  typedef logic [15:0] word_t;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StTooBig  = 3'd1;
  localparam logic [2:0] StNoSpace = 3'd2;
  localparam logic [2:0] StRange   = 3'd3;
  localparam logic [2:0] StNotProc = 3'd4;
  localparam logic [2:0] StFull    = 3'd5;

  localparam logic [1:0] RegCapacity = 2'd0;
  localparam logic [1:0] RegLowest   = 2'd1;
  localparam logic [1:0] RegHighest  = 2'd2;
  localparam logic [1:0] RegInitial  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_ALLOC,
    S_SHIFT_UP,
    S_FREE,
    S_SHIFT_DN,
    S_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic init;      // reload single hole
    logic load;      // capture request
    logic scan_rst;  // pointer to 0
    logic scan_inc;  // pointer forward
    logic do_alloc;  // split or convert found hole
    logic shift_up;  // move one entry up
    logic do_free;   // mark free and merge
    logic shift_dn;  // move one entry down
    logic set_res;   // write result register
    logic [2:0] res_status;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_alloc;
    logic too_big;
    logic out_range;
    logic hit;        // alloc: fitting hole at pointer; free: stop at pointer
    logic at_end;     // pointer is last used entry
    logic exact;      // found hole has exactly requested length
    logic full;
    logic sel_hole;   // free: selected entry already a hole
    logic shift_done; // shift pointer reached target
  } stat_t;

endpackage

FILE: rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl: request sequencer
// Steps each request through search, update, table shift and result.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           res_busy_i,
  input  ffsa_pkg::stat_t st_i,
  output ffsa_pkg::cmd_t  cmd_o
);
  import ffsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (st_i.is_alloc) begin
          if (st_i.too_big) state_d = S_DONE;
          else if (st_i.hit) state_d = S_ALLOC;
          else if (st_i.at_end) state_d = S_DONE;
        end else begin
          if (st_i.out_range) state_d = S_DONE;
          else if (st_i.hit) state_d = st_i.sel_hole ? S_DONE : S_FREE;
        end
      end
      S_ALLOC: begin
        if (st_i.exact || st_i.full) state_d = S_DONE;
        else state_d = S_SHIFT_UP;
      end
      S_SHIFT_UP: begin
        if (st_i.shift_done) state_d = S_DONE;
      end
      S_FREE:     state_d = S_SHIFT_DN;
      S_SHIFT_DN: begin
        if (st_i.shift_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_busy_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = StOk;
    case (state_q)
      S_IDLE: begin
        cmd_o.load     = in_valid_i;
        cmd_o.scan_rst = in_valid_i;
      end
      S_SEARCH: begin
        if (st_i.is_alloc) begin
          if (st_i.too_big) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_status = StTooBig;
          end else if (!st_i.hit && st_i.at_end) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_status = StNoSpace;
          end else if (!st_i.hit) begin
            cmd_o.scan_inc = 1'b1;
          end
        end else begin
          if (st_i.out_range) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_status = StRange;
          end else if (st_i.hit && st_i.sel_hole) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_status = StNotProc;
          end else if (!st_i.hit) begin
            cmd_o.scan_inc = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        if (st_i.exact) begin
          cmd_o.do_alloc = 1'b1;
          cmd_o.set_res  = 1'b1;
        end else if (st_i.full) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = StFull;
        end else begin
          cmd_o.set_res = 1'b1;
        end
      end
      S_SHIFT_UP: begin
        cmd_o.shift_up = 1'b1;
        cmd_o.do_alloc = st_i.shift_done;
      end
      S_FREE: begin
        cmd_o.do_free = 1'b1;
        cmd_o.set_res = 1'b1;
      end
      S_SHIFT_DN: cmd_o.shift_dn = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/ffsa_dp.sv
// ----------------------------------------------------------------------------
// ffsa_dp: segment table and request datapath
// Holds the table, scan and shift pointers, merge logic and result register.
// ----------------------------------------------------------------------------
module ffsa_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffsa_pkg::cmd_t   cmd_i,
  output ffsa_pkg::stat_t  st_o,
  input  logic             operation_i,
  input  ffsa_pkg::word_t  alloc_size_i,
  input  ffsa_pkg::word_t  free_address_i,
  input  ffsa_pkg::word_t  capacity_i,
  input  ffsa_pkg::word_t  lowest_i,
  input  ffsa_pkg::word_t  highest_i,
  input  ffsa_pkg::word_t  initial_i,
  input  logic             out_take_i,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output ffsa_pkg::word_t  granted_address_o,
  output logic [1:0]       merge_kind_o
);
  import ffsa_pkg::*;

  word_t                  start_q [MaxSegments];
  word_t                  len_q   [MaxSegments];
  logic [MaxSegments-1:0] hole_q;
  logic [CntW-1:0]        count_q;
  logic [IdxW-1:0]        ptr_q;   // found entry
  logic [IdxW-1:0]        sp_q;    // shift pointer
  logic [IdxW-1:0]        stop_q;  // shift target
  logic                   op_q;
  word_t                  size_q, addr_q;
  logic                   vld_q;
  logic [2:0]             sts_q;
  word_t                  gnt_q;
  logic [1:0]             kind_q;

  logic [IdxW-1:0] last_idx, ptr_p1, ptr_m1, sp_p1;
  logic            left, right;
  logic [16:0]     sum_lr, sum_l, sum_r;
  word_t           sat_lr, sat_l, sat_r;

  assign last_idx = IdxW'(count_q - CntW'(1));
  assign ptr_p1   = ptr_q + IdxW'(1);
  assign ptr_m1   = ptr_q - IdxW'(1);
  assign sp_p1    = sp_q + IdxW'(1);

  assign left  = (ptr_q != '0) && hole_q[ptr_m1];
  assign right = (CntW'(ptr_q) + CntW'(1) < count_q) && hole_q[ptr_p1];

  // Saturating merge sums; nested saturation matches two-step add.
  assign sum_r   = {1'b0, len_q[ptr_q]} + {1'b0, len_q[ptr_p1]};
  assign sat_r   = sum_r[16] ? 16'hFFFF : sum_r[15:0];
  assign sum_l   = {1'b0, len_q[ptr_m1]} + {1'b0, len_q[ptr_q]};
  assign sat_l   = sum_l[16] ? 16'hFFFF : sum_l[15:0];
  assign sum_lr  = {1'b0, len_q[ptr_m1]} + {1'b0, sat_r};
  assign sat_lr  = sum_lr[16] ? 16'hFFFF : sum_lr[15:0];

  always_comb begin
    st_o = '0;
    st_o.is_alloc  = !op_q;
    st_o.too_big   = size_q > capacity_i;
    st_o.out_range = (addr_q >= highest_i) || (addr_q < lowest_i);
    st_o.at_end    = (ptr_q == last_idx);
    st_o.hit       = op_q ? ((start_q[ptr_q] >= addr_q) || (ptr_q == last_idx))
                          : (hole_q[ptr_q] && (len_q[ptr_q] >= size_q));
    st_o.exact     = (len_q[ptr_q] == size_q);
    st_o.full      = (count_q == CntW'(MaxSegments));
    st_o.sel_hole  = hole_q[ptr_q];
    st_o.shift_done = (sp_q == stop_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      size_q <= alloc_size_i;
      addr_q <= free_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_rst) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_inc) begin
      ptr_q <= ptr_p1;
    end
  end

  // Table and shift control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxSegments; k++) begin
        start_q[k] <= '0;
        len_q[k]   <= '0;
      end
      start_q[0] <= 16'd0;
      len_q[0]   <= 16'd256;
      hole_q     <= MaxSegments'(1);
      count_q    <= CntW'(1);
      sp_q       <= '0;
      stop_q     <= '0;
    end else if (cmd_i.init) begin
      start_q[0] <= initial_i;
      len_q[0]   <= capacity_i;
      hole_q     <= MaxSegments'(1);
      count_q    <= CntW'(1);
    end else begin
      if (cmd_i.set_res && !op_q && !st_o.exact && !st_o.full &&
          cmd_i.res_status == StOk) begin
        // Start moving entries up from the top, down to ptr+1.
        sp_q   <= IdxW'(count_q);
        stop_q <= ptr_p1;
      end
      if (cmd_i.shift_up && !st_o.shift_done) begin
        start_q[sp_q] <= start_q[sp_q - IdxW'(1)];
        len_q[sp_q]   <= len_q[sp_q - IdxW'(1)];
        hole_q[sp_q]  <= hole_q[sp_q - IdxW'(1)];
        sp_q          <= sp_q - IdxW'(1);
      end
      if (cmd_i.do_alloc) begin
        hole_q[ptr_q] <= 1'b0;
        if (!st_o.exact) begin
          len_q[ptr_q]   <= size_q;
          len_q[ptr_p1]  <= len_q[ptr_q] - size_q;
          start_q[ptr_p1] <= start_q[ptr_q] + (size_q >> UnitShift);
          hole_q[ptr_p1] <= 1'b1;
          count_q        <= count_q + CntW'(1);
        end
      end
      if (cmd_i.do_free) begin
        hole_q[ptr_q] <= 1'b1;
        if (left && right) begin
          len_q[ptr_m1] <= sat_lr;
          sp_q   <= ptr_q;
          stop_q <= IdxW'(count_q - CntW'(2));
          count_q <= count_q - CntW'(2);
        end else if (left) begin
          len_q[ptr_m1] <= sat_l;
          sp_q   <= ptr_q;
          stop_q <= IdxW'(count_q - CntW'(1));
          count_q <= count_q - CntW'(1);
        end else if (right) begin
          len_q[ptr_q] <= sat_r;
          sp_q   <= ptr_p1;
          stop_q <= IdxW'(count_q - CntW'(1));
          count_q <= count_q - CntW'(1);
        end else begin
          sp_q   <= '0;
          stop_q <= '0;
        end
      end
      if (cmd_i.shift_dn && !st_o.shift_done) begin
        // Distance is 2 for a double merge, else 1.
        if (kind_q == 2'd3) begin
          start_q[sp_q] <= start_q[sp_q + IdxW'(2)];
          len_q[sp_q]   <= len_q[sp_q + IdxW'(2)];
          hole_q[sp_q]  <= hole_q[sp_q + IdxW'(2)];
        end else begin
          start_q[sp_q] <= start_q[sp_p1];
          len_q[sp_q]   <= len_q[sp_p1];
          hole_q[sp_q]  <= hole_q[sp_p1];
        end
        sp_q <= sp_p1;
      end
    end
  end

  // Result register; holds until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      sts_q  <= StOk;
      gnt_q  <= '0;
      kind_q <= '0;
    end else begin
      if (out_take_i) vld_q <= 1'b0;
      if (cmd_i.set_res) begin
        vld_q <= 1'b1;
        sts_q <= cmd_i.res_status;
        gnt_q <= (!op_q && cmd_i.res_status == StOk) ? start_q[ptr_q] : '0;
        if (!op_q || cmd_i.res_status != StOk) kind_q <= '0;
      end
      if (cmd_i.do_free) kind_q <= {left, right};
    end
  end

  assign out_valid_o       = vld_q;
  assign status_o          = sts_q;
  assign granted_address_o = gnt_q;
  assign merge_kind_o      = kind_q;

endmodule

FILE: rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: first-fit segment table with coalescing
// Allocates and frees segments in an address-ordered table of holes and
// processes, one request at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o  | operation, alloc_size, free_address
//  out     | output    | out_valid_o/out_stall_i| status, granted_address, merge_kind
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// The scan visits one table entry per cycle, and a split or merge then moves
// one entry per cycle, so scan and moves together touch each entry about once.
// The result register is written once the scan ends, before any entry moves.
// Reset loads a single hole of 256 bytes at address 0; no clearing pass.
// A capacity or base write reloads the table the next cycle and stalls input
// for that cycle. A new request is taken only once the previous result has
// been transferred. A stalled result holds its value.
module first_fit_segment_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] alloc_size_i,
  input  logic [15:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] granted_address_o,
  output logic [1:0]  merge_kind_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ffsa_pkg::*;

  cmd_t  cmd, cmd_c;
  stat_t st;
  word_t cap_q, low_q, high_q, init_q;
  logic  busy, cfg_we, table_init_q, ctrl_stall;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // Bound registers act at once; a capacity or base write reloads the table
  // on the following cycle from the new register values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 16'd256;
      low_q  <= 16'd0;
      high_q <= 16'd256;
      init_q <= 16'd0;
      table_init_q <= 1'b0;
    end else begin
      table_init_q <= 1'b0;
      if (cfg_we) begin
        case (cfg_index_i)
          RegCapacity: begin
            cap_q <= cfg_data_i;
            table_init_q <= 1'b1;
          end
          RegLowest:  low_q  <= cfg_data_i;
          RegHighest: high_q <= cfg_data_i;
          RegInitial: begin
            init_q <= cfg_data_i;
            table_init_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // The result register blocks completion until the previous result leaves.
  assign busy = out_valid_o && out_stall_i;

  // Input is held off during the table reload cycle as well.
  assign in_stall_o = ctrl_stall || table_init_q;

  ffsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !table_init_q),
    .in_stall_o (ctrl_stall),
    .res_busy_i (busy),
    .st_i       (st),
    .cmd_o      (cmd_c)
  );

  always_comb begin
    cmd = cmd_c;
    cmd.init = table_init_q;
  end

  ffsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .operation_i       (operation_i),
    .alloc_size_i      (alloc_size_i),
    .free_address_i    (free_address_i),
    .capacity_i        (cap_q),
    .lowest_i          (low_q),
    .highest_i         (high_q),
    .initial_i         (init_q),
    .out_take_i        (out_valid_o && !out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .merge_kind_o      (merge_kind_o)
  );

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the first-fit segment allocator
// Drives allocate and free requests through the valid/stall channels, keeps a
// shadow segment table that predicts every result, and compares each result
// transfer field by field. Configuration is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic        op;
    logic [15:0] size;
    logic [15:0] addr;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted;
    logic [1:0]  kind;
  } grant_t;

  // One directed row: the request, and optionally a typed-in result.
  typedef struct packed {
    request_t req;
    logic     fixed;
    grant_t   res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = 1'b0;
  logic [15:0] alloc_size_i = '0;
  logic [15:0] free_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] granted_address_o;
  logic [1:0]  merge_kind_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  first_fit_segment_allocator i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration and of the segment table.
  word_t       cap_q, low_q, high_q, init_q;
  word_t       sh_start [MaxSegments];
  word_t       sh_len   [MaxSegments];
  logic        sh_hole  [MaxSegments];
  int unsigned sh_count;

  grant_t      pending_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned idle_cycles = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};
  bit          quiet = 1'b0;  // no idling in the closing stretch
  bit          timed_out = 1'b0;

  task automatic table_reload();
    for (int k = 0; k < MaxSegments; k++) begin
      sh_start[k] = '0;
      sh_len[k]   = '0;
      sh_hole[k]  = 1'b0;
    end
    sh_start[0] = init_q;
    sh_len[0]   = cap_q;
    sh_hole[0]  = 1'b1;
    sh_count    = 1;
  endtask

  task automatic table_remove(int unsigned k);
    if (k < sh_count) begin
      for (int unsigned j = k; j + 1 < sh_count; j++) begin
        sh_start[j] = sh_start[j+1];
        sh_len[j]   = sh_len[j+1];
        sh_hole[j]  = sh_hole[j+1];
      end
      sh_count--;
      sh_start[sh_count] = '0;
      sh_len[sh_count]   = '0;
      sh_hole[sh_count]  = 1'b0;
    end
  endtask

  function automatic word_t sat16(int unsigned a, int unsigned b);
    return (a + b > 65535) ? 16'hFFFF : word_t'(a + b);
  endfunction

  // Predicts the result of one request and updates the shadow table.
  task automatic predict_grant(input request_t r, output grant_t g);
    int unsigned i;
    bit          lft, rgt;
    g = '0;
    if (r.op == OpAlloc) begin
      if (r.size > cap_q) begin
        g.status = StTooBig;
        return;
      end
      for (i = 0; i < sh_count; i++) if (sh_hole[i] && sh_len[i] >= r.size) break;
      if (i >= sh_count) begin
        g.status = StNoSpace;
      end else if (sh_len[i] == r.size) begin
        sh_hole[i] = 1'b0;
        g.status = StOk;
        g.granted = sh_start[i];
      end else if (sh_count >= MaxSegments) begin
        g.status = StFull;
      end else begin
        for (int unsigned j = sh_count; j > i; j--) begin
          sh_start[j] = sh_start[j-1];
          sh_len[j]   = sh_len[j-1];
          sh_hole[j]  = sh_hole[j-1];
        end
        sh_count++;
        sh_hole[i]    = 1'b0;
        sh_len[i]     = r.size;
        sh_len[i+1]   = sh_len[i+1] - r.size;
        sh_start[i+1] = sh_start[i] + word_t'(r.size / BytesPerUnit);
        g.status  = StOk;
        g.granted = sh_start[i];
      end
    end else begin
      if (r.addr >= high_q || r.addr < low_q) begin
        g.status = StRange;
        return;
      end
      for (i = 0; i + 1 < sh_count; i++) if (sh_start[i] >= r.addr) break;
      if (sh_hole[i]) begin
        g.status = StNotProc;
        return;
      end
      sh_hole[i] = 1'b1;
      lft = (i > 0) && sh_hole[i-1];
      rgt = (i + 1 < sh_count) && sh_hole[i+1];
      g.status = StOk;
      if (lft && rgt) begin
        sh_len[i-1] = sat16(sh_len[i-1], sat16(sh_len[i], sh_len[i+1]));
        table_remove(i + 1);
        table_remove(i);
        g.kind = 2'd3;
      end else if (lft) begin
        sh_len[i-1] = sat16(sh_len[i-1], sh_len[i]);
        table_remove(i);
        g.kind = 2'd2;
      end else if (rgt) begin
        sh_len[i] = sat16(sh_len[i], sh_len[i+1]);
        table_remove(i + 1);
        g.kind = 2'd1;
      end
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_recv, what, got, want);
  endtask

  // Random idle burst, skipped in the closing stretch.
  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge clk_i);
  endtask

  // Register writes happen only with nothing outstanding; a quiet pause covers
  // the longest request after the final result.
  task automatic write_reg(logic [1:0] idx, word_t val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegCapacity: begin cap_q = val; table_reload(); end
      RegLowest:   low_q = val;
      RegHighest:  high_q = val;
      default:     begin init_q = val; table_reload(); end
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (2 * MaxSegments + 8) @(negedge clk_i);
  endtask

  // Sends one request; the expectation is queued at the accepting edge.
  task automatic send_request(request_t r, bit fixed, grant_t want);
    grant_t g;
    idle_burst();
    in_valid_i     = 1'b1;
    operation_i    = r.op;
    alloc_size_i   = r.size;
    free_address_i = r.addr;
    do @(posedge clk_i); while (in_stall_o);
    predict_grant(r, g);
    if (fixed && g != want) begin
      errors++;
      $display("DIRECTED row %0d: shadow table disagrees with typed result", n_sent);
    end
    pending_q.push_back(fixed ? want : g);
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Result side: random stall bursts and field-by-field comparison.
  initial begin
    grant_t w;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        n_recv++;
        if (pending_q.size() == 0) begin
          errors++;
          $display("UNEXPECTED result %0d with nothing pending", n_recv);
        end else begin
          w = pending_q.pop_front();
          if (status_o !== w.status) report_mismatch("status", status_o, w.status);
          if (granted_address_o !== w.granted)
            report_mismatch("granted_address", granted_address_o, w.granted);
          if (merge_kind_o !== w.kind) report_mismatch("merge_kind", merge_kind_o, w.kind);
          if (w.status == StOk) kind_seen[w.kind]++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out <= 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic row_t mk(logic op, int unsigned sz, int unsigned ad, bit fx = 0,
                              logic [2:0] st = 0, int unsigned ga = 0, int unsigned mk_k = 0);
    row_t r;
    r.req   = '{op, sz[15:0], ad[15:0]};
    r.fixed = fx;
    r.res   = '{st, ga[15:0], mk_k[1:0]};
    return r;
  endfunction

  // Picks a free address that usually names the start of a table entry.
  function automatic word_t pick_free_addr();
    int unsigned k;
    if ($urandom_range(0, 9) < 7 && sh_count > 0) begin
      k = $urandom_range(0, sh_count - 1);
      return sh_start[k];
    end
    return word_t'($urandom);
  endfunction

  function automatic word_t pick_size();
    case ($urandom_range(0, 9))
      0:       return word_t'($urandom);
      1:       return 16'd0;
      2:       return cap_q;
      default: return word_t'($urandom_range(1, 48));
    endcase
  endfunction

  initial begin
    row_t     rows[$];
    request_t r;
    word_t    caps[4] = '{16'd256, 16'd65535, 16'd64, 16'd0};
    word_t    inits[4] = '{16'd0, 16'd65520, 16'd4096, 16'd65535};
    cap_q = 16'd256; low_q = '0; high_q = 16'd256; init_q = '0;
    table_reload();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: after-reset table of one 256-byte hole at address 0.
    rows.push_back(mk(OpFree, 0, 0, 1, StNotProc));          // free of the hole itself
    rows.push_back(mk(OpAlloc, 257, 0, 1, StTooBig));        // larger than capacity
    rows.push_back(mk(OpAlloc, 65535, 0, 1, StTooBig));
    rows.push_back(mk(OpFree, 0, 256, 1, StRange));          // at the upper bound
    rows.push_back(mk(OpFree, 0, 65535, 1, StRange));
    rows.push_back(mk(OpAlloc, 16, 0, 1, StOk, 0));          // split at the start
    rows.push_back(mk(OpAlloc, 0, 0));                       // zero-length process
    rows.push_back(mk(OpAlloc, 32, 0));
    rows.push_back(mk(OpAlloc, 8, 0));
    rows.push_back(mk(OpFree, 0, 4));                        // merge cases follow
    rows.push_back(mk(OpFree, 0, 12));
    rows.push_back(mk(OpFree, 0, 0));
    rows.push_back(mk(OpAlloc, 256, 0));                     // no room left of that size
    rows.push_back(mk(OpAlloc, 200, 0));
    rows.push_back(mk(OpAlloc, 56, 0));                      // no hole that large remains
    rows.push_back(mk(OpFree, 0, 50));
    rows.push_back(mk(OpFree, 0, 1));
    for (int k = 0; k < 17; k++) rows.push_back(mk(OpAlloc, 1, 0)); // fill the table
    foreach (rows[k]) send_request(rows[k].req, rows[k].fixed, rows[k].res);
    drain();

    // Random phases, each under its own configuration.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegInitial, inits[ph % 4]);
      write_reg(RegCapacity, caps[ph % 4]);
      write_reg(RegLowest, (ph % 3 == 0) ? 16'd0 : word_t'($urandom_range(0, 300)));
      write_reg(RegHighest, (ph % 3 == 1) ? 16'hFFFF : word_t'($urandom));
      if (ph == 7) quiet = 1'b1;
      for (int n = 0; n < 180; n++) begin
        r.op   = ($urandom_range(0, 1) == 1) ? OpFree : OpAlloc;
        r.size = pick_size();
        r.addr = pick_free_addr();
        if (sh_count >= MaxSegments - 1 && $urandom_range(0, 1)) r.op = OpFree;
        send_request(r, 1'b0, '0);
      end
      drain();
    end

    $display("Covered %0d requests, %0d results; merges none/right/left/both: %0d/%0d/%0d/%0d",
             n_sent, n_recv, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("Configuration swept over capacity, bounds and initial address extremes.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: first_fit_segment_allocator.f
rtl/ffsa_pkg.sv
rtl/ffsa_ctrl.sv
rtl/ffsa_dp.sv
rtl/first_fit_segment_allocator.sv
bench/tb.sv
